// ===== hw/rtl/aging_page_replacement_defines.svh =====
// Assertion macros shared by the aging page replacement RTL.
`ifndef AGING_PAGE_REPLACEMENT_DEFINES_SVH
`define AGING_PAGE_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define APR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define APR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/apr_pkg.sv =====
// Package with constants and types for the aging page replacement block.
`timescale 1ns / 1ps

package apr_pkg;

  localparam int FRAMES_DEF    = 4;
  localparam int AGE_BITS_DEF  = 24;
  localparam int PAGE_BITS_DEF = 20;

  localparam int OUT_IDX_BITS  = 2;
  localparam int INTERVAL_BITS = 8;
  localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = 8'd3;

  // Result of comparing one frame against the request and the current victim.
  typedef struct packed {
    logic match;
    logic absent;
    logic younger;
  } apr_cmp_t;

endpackage

// ===== hw/rtl/apr_frame_cmp.sv =====
// Shared frame compare unit: page match, absent frame and age ordering.
`timescale 1ns / 1ps

module apr_frame_cmp #(
  parameter int PAGE_BITS = apr_pkg::PAGE_BITS_DEF,
  parameter int AGE_BITS  = apr_pkg::AGE_BITS_DEF
) (
  input  logic [PAGE_BITS-1:0] req_page,
  input  logic [PAGE_BITS-1:0] frame_page,
  input  logic                 frame_present,
  input  logic [AGE_BITS-1:0]  frame_age,
  input  logic [AGE_BITS-1:0]  best_age,
  output apr_pkg::apr_cmp_t    res
);

  always_comb begin
    res.match   = frame_present && (frame_page == req_page);
    res.absent  = !frame_present;
    res.younger = frame_age < best_age;
  end

endmodule

// ===== hw/rtl/aging_page_replacement.sv =====
// Top level of the aging page replacement block.
`timescale 1ns / 1ps
`include "aging_page_replacement_defines.svh"

// Aging page replacement over a small table of frames.
// Input channel: in_valid / in_stall carry one page number per transfer.
// Result channel: out_valid / out_stall carry hit, frame index, the evicted
// frame's page, present bit and age, and whether an aging pass ran.
// Configuration: cfg_wr_en writes cfg_wr_data into the aging interval.
// A request passes through an idle state that takes it, a scan state that
// checks one frame per cycle through the shared compare unit, and a commit
// state that updates the frame, runs the aging pass when it is due and
// loads the output register.
// The scan stops early on a hit or on an absent frame.
// The input is stalled from acceptance until the commit cycle is done.
// A stalled result waits in the output register; the next request can be
// taken and scanned meanwhile, but its commit waits until the result moves.
// Reset clears all frames, the interval count and the output valid, and
// sets the aging interval to 3.
module aging_page_replacement #(
  parameter int FRAMES    = apr_pkg::FRAMES_DEF,
  parameter int AGE_BITS  = apr_pkg::AGE_BITS_DEF,
  parameter int PAGE_BITS = apr_pkg::PAGE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [PAGE_BITS-1:0]                 in_page_request,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_hit,
  output logic [apr_pkg::OUT_IDX_BITS-1:0]     out_frame_index,
  output logic [PAGE_BITS-1:0]                 out_evicted_page,
  output logic                                 out_evicted_present,
  output logic [AGE_BITS-1:0]                  out_evicted_age,
  output logic                                 out_aged,
  input  logic                                 cfg_wr_en,
  input  logic [apr_pkg::INTERVAL_BITS-1:0]    cfg_wr_data
);

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAMES - 1);
  localparam logic [AGE_BITS-1:0] AGE_TOP = {1'b1, {(AGE_BITS-1){1'b0}}};

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [IDX_W-1:0]     pick_r, pick_nxt;
  logic [PAGE_BITS-1:0] req_r, req_nxt;
  logic                 hit_r, hit_nxt;
  logic [PAGE_BITS-1:0] ev_page_r, ev_page_nxt;
  logic [AGE_BITS-1:0]  ev_age_r, ev_age_nxt;
  logic                 ev_present_r, ev_present_nxt;

  logic [PAGE_BITS-1:0] page_r [FRAMES];
  logic [PAGE_BITS-1:0] page_nxt [FRAMES];
  logic [AGE_BITS-1:0]  age_r [FRAMES];
  logic [AGE_BITS-1:0]  age_nxt [FRAMES];
  logic [FRAMES-1:0]    present_r, present_nxt;
  logic [FRAMES-1:0]    ref_r, ref_nxt;

  logic [apr_pkg::INTERVAL_BITS-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [apr_pkg::INTERVAL_BITS-1:0] interval_r;

  logic                                out_valid_r;
  logic                                out_hit_r;
  logic [apr_pkg::OUT_IDX_BITS-1:0]    out_frame_index_r;
  logic [PAGE_BITS-1:0]                out_evicted_page_r;
  logic                                out_evicted_present_r;
  logic [AGE_BITS-1:0]                 out_evicted_age_r;
  logic                                out_aged_r;

  logic              out_free;
  logic              commit;
  logic              do_age;
  apr_pkg::apr_cmp_t cmp;

  apr_frame_cmp #(
    .PAGE_BITS(PAGE_BITS),
    .AGE_BITS (AGE_BITS)
  ) u_cmp (
    .req_page     (req_r),
    .frame_page   (page_r[idx_r]),
    .frame_present(present_r[idx_r]),
    .frame_age    (age_r[idx_r]),
    .best_age     (ev_age_r),
    .res          (cmp)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign commit   = (state_r == ST_DONE) && out_free;
  assign do_age   = (cnt_r == '0);
  assign in_stall = (state_r != ST_IDLE);

  // Sequencer: take a request, scan the frames one per cycle, then commit.
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    pick_nxt       = pick_r;
    req_nxt        = req_r;
    hit_nxt        = hit_r;
    ev_page_nxt    = ev_page_r;
    ev_age_nxt     = ev_age_r;
    ev_present_nxt = ev_present_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_page_request;
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cmp.match) begin
          hit_nxt   = 1'b1;
          pick_nxt  = idx_r;
          state_nxt = ST_DONE;
        end else if (cmp.absent) begin
          pick_nxt       = idx_r;
          ev_page_nxt    = page_r[idx_r];
          ev_age_nxt     = age_r[idx_r];
          ev_present_nxt = 1'b0;
          state_nxt      = ST_DONE;
        end else begin
          // The first frame is the starting victim; later ones replace it
          // only when strictly younger, so ties keep the earlier frame.
          if ((idx_r == '0) || cmp.younger) begin
            pick_nxt       = idx_r;
            ev_page_nxt    = page_r[idx_r];
            ev_age_nxt     = age_r[idx_r];
            ev_present_nxt = 1'b1;
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_DONE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Frame update on commit, followed by the aging pass when it is due.
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      page_nxt[i]    = page_r[i];
      age_nxt[i]     = age_r[i];
      present_nxt[i] = present_r[i];
      ref_nxt[i]     = ref_r[i];
      if (commit && (IDX_W'(i) == pick_r)) begin
        ref_nxt[i] = 1'b1;
        if (!hit_r) begin
          page_nxt[i]    = req_r;
          present_nxt[i] = 1'b1;
          age_nxt[i]     = AGE_TOP;
        end
      end
      if (commit && do_age) begin
        age_nxt[i] = {ref_nxt[i], age_nxt[i][AGE_BITS-1:1]};
        ref_nxt[i] = 1'b0;
      end
    end
  end

  always_comb begin
    cnt_inc = cnt_r + 1'b1;
    cnt_nxt = (cnt_inc >= interval_r) ? '0 : cnt_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      interval_r <= apr_pkg::INTERVAL_RESET;
      present_r  <= '0;
      ref_r      <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        page_r[i] <= '0;
        age_r[i]  <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      present_r <= present_nxt;
      ref_r     <= ref_nxt;
      for (int i = 0; i < FRAMES; i++) begin
        page_r[i] <= page_nxt[i];
        age_r[i]  <= age_nxt[i];
      end
      if (commit) begin
        cnt_r <= cnt_nxt;
      end
      if (cfg_wr_en) begin
        interval_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pick_r       <= pick_nxt;
    req_r        <= req_nxt;
    hit_r        <= hit_nxt;
    ev_page_r    <= ev_page_nxt;
    ev_age_r     <= ev_age_nxt;
    ev_present_r <= ev_present_nxt;
  end

  // Output register: loaded on commit, cleared once the transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_hit_r             <= hit_r;
      out_frame_index_r     <= apr_pkg::OUT_IDX_BITS'(pick_r);
      out_evicted_page_r    <= hit_r ? '0 : ev_page_r;
      out_evicted_present_r <= hit_r ? 1'b0 : ev_present_r;
      out_evicted_age_r     <= hit_r ? '0 : ev_age_r;
      out_aged_r            <= do_age;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hit             = out_hit_r;
  assign out_frame_index     = out_frame_index_r;
  assign out_evicted_page    = out_evicted_page_r;
  assign out_evicted_present = out_evicted_present_r;
  assign out_evicted_age     = out_evicted_age_r;
  assign out_aged            = out_aged_r;

  `APR_ASSERT_NEXT(a_accept_starts_scan, in_valid && !in_stall, state_r == ST_SCAN,
                   "accepted request did not start a scan")
  `APR_ASSERT_NOW(a_valid_from_commit, $rose(out_valid_r), $past(state_r) == ST_DONE,
                  "result appeared without a commit")
  `APR_ASSERT_NOW(a_hit_no_evict, out_valid_r && out_hit_r,
                  out_evicted_page_r == '0 && out_evicted_age_r == '0 && !out_evicted_present_r,
                  "hit result carries eviction data")
  `APR_ASSERT_NOW(a_scan_idx_range, state_r == ST_SCAN, idx_r <= LAST_IDX,
                  "scan index beyond last frame")
  `APR_ASSERT_NEXT(a_commit_updates_frame, commit,
                   present_r[pick_r] && ref_r[pick_r] || $past(do_age),
                   "committed frame not present and referenced")

endmodule

// ===== dv/aging_page_replacement_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the aging page replacement block.
module aging_page_replacement_tb;

  localparam int FRAMES = apr_pkg::FRAMES_DEF;
  localparam int AGE_BITS = apr_pkg::AGE_BITS_DEF;
  localparam int PAGE_BITS = apr_pkg::PAGE_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic                             hit;
    logic [apr_pkg::OUT_IDX_BITS-1:0] frame;
    logic [PAGE_BITS-1:0]             victim_page;
    logic                             victim_present;
    logic [AGE_BITS-1:0]              victim_age;
    logic                             aged;
  } lookup_t;

  class page_table_scoreboard;
    logic [PAGE_BITS-1:0] page_of [FRAMES];
    bit present [FRAMES];
    bit referenced [FRAMES];
    logic [AGE_BITS-1:0] age [FRAMES];
    bit [apr_pkg::INTERVAL_BITS-1:0] interval;
    bit [apr_pkg::INTERVAL_BITS-1:0] count;
    lookup_t expected_q[$];
    logic [PAGE_BITS-1:0] request_q[$];
    int mismatches;

    function new();
      for (int i = 0; i < FRAMES; i++) begin
        page_of[i] = '0;
        present[i] = 1'b0;
        referenced[i] = 1'b0;
        age[i] = '0;
      end
      interval = apr_pkg::INTERVAL_RESET;
      count = '0;
      mismatches = 0;
    endfunction

    function void set_interval(bit [apr_pkg::INTERVAL_BITS-1:0] value);
      interval = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Works out the lookup result of one accepted request and updates the table.
    function void note_request(logic [PAGE_BITS-1:0] req);
      lookup_t r;
      int found;
      int pick;
      bit done;
      found = -1;
      pick = 0;
      done = 1'b0;
      // The scan ends at a match or at the first empty frame.
      for (int i = 0; i < FRAMES; i++) begin
        if (!done) begin
          if (present[i] && page_of[i] == req) begin
            found = i;
            done = 1'b1;
          end else if (!present[i]) begin
            pick = i;
            done = 1'b1;
          end else if (age[i] < age[pick]) begin
            pick = i;
          end
        end
      end
      r = '0;
      if (found >= 0) begin
        referenced[found] = 1'b1;
        r.hit = 1'b1;
        r.frame = apr_pkg::OUT_IDX_BITS'(found);
      end else begin
        r.frame = apr_pkg::OUT_IDX_BITS'(pick);
        r.victim_page = page_of[pick];
        r.victim_present = present[pick];
        r.victim_age = age[pick];
        page_of[pick] = req;
        present[pick] = 1'b1;
        referenced[pick] = 1'b1;
        age[pick] = {1'b1, {(AGE_BITS-1){1'b0}}};
      end
      r.aged = (count == 0);
      if (r.aged) begin
        for (int i = 0; i < FRAMES; i++) begin
          age[i] = {referenced[i], age[i][AGE_BITS-1:1]};
          referenced[i] = 1'b0;
        end
      end
      count = count + 1'b1;
      if (count >= interval) count = '0;
      expected_q.push_back(r);
      request_q.push_back(req);
    endfunction

    function void check_result(lookup_t got);
      lookup_t want;
      logic [PAGE_BITS-1:0] req;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with no request outstanding: %h", $realtime, got);
        return;
      end
      want = expected_q.pop_front();
      req = request_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: mismatch for page %h", $realtime, req);
          $display("  hit      expected %0d got %0d", want.hit, got.hit);
          $display("  frame    expected %0d got %0d", want.frame, got.frame);
          $display("  ev_page  expected %h got %h", want.victim_page, got.victim_page);
          $display("  ev_pres  expected %0d got %0d", want.victim_present, got.victim_present);
          $display("  ev_age   expected %h got %h", want.victim_age, got.victim_age);
          $display("  aged     expected %0d got %0d", want.aged, got.aged);
        end
      end
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [PAGE_BITS-1:0]              in_page_request = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic                              out_hit;
  logic [apr_pkg::OUT_IDX_BITS-1:0]  out_frame_index;
  logic [PAGE_BITS-1:0]              out_evicted_page;
  logic                              out_evicted_present;
  logic [AGE_BITS-1:0]               out_evicted_age;
  logic                              out_aged;
  logic                              cfg_wr_en = 1'b0;
  logic [apr_pkg::INTERVAL_BITS-1:0] cfg_wr_data = '0;

  page_table_scoreboard sb;
  lookup_t observed;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int quiet;

  logic [PAGE_BITS-1:0] directed_pages [20] = '{
    20'h00000, 20'h00000, 20'hFFFFF, 20'h00001, 20'h80000,
    20'hFFFFF, 20'h7FFFF, 20'h55555, 20'hAAAAA, 20'h00000,
    20'h80000, 20'h00001, 20'hFFFFF, 20'h12345, 20'h7FFFF,
    20'h55555, 20'h55555, 20'hAAAAA, 20'hFEDCB, 20'h00000
  };

  aging_page_replacement dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_page_request     (in_page_request),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_hit             (out_hit),
    .out_frame_index     (out_frame_index),
    .out_evicted_page    (out_evicted_page),
    .out_evicted_present (out_evicted_present),
    .out_evicted_age     (out_evicted_age),
    .out_aged            (out_aged),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  assign observed = {out_hit, out_frame_index, out_evicted_page, out_evicted_present,
                     out_evicted_age, out_aged};

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(observed);
  end

  // Ends the run when no transfer happens on either channel for too long.
  initial begin
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("aging_page_replacement verification failed");
    $finish;
  end

  task automatic send_request(logic [PAGE_BITS-1:0] page);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk) in_valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_page_request <= page;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(page);
  endtask

  task automatic drain_results();
    @(negedge clk) in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_interval(logic [apr_pkg::INTERVAL_BITS-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk) cfg_wr_en <= 1'b0;
    sb.set_interval(value);
  endtask

  // Mostly requests from a small working set, so that hits and age-based
  // evictions dominate; the rest are arbitrary pages.
  task automatic run_phase(logic [apr_pkg::INTERVAL_BITS-1:0] interval, int send_pct,
                           int stall, int count);
    logic [PAGE_BITS-1:0] pool [8];
    logic [PAGE_BITS-1:0] page;
    int pool_size;
    drain_results();
    write_interval(interval);
    sender_idle_pct = send_pct;
    stall_pct = stall;
    pool_size = $urandom_range(8, 5);
    foreach (pool[i]) pool[i] = PAGE_BITS'($urandom);
    repeat (count) begin
      if ($urandom_range(99) < 75) page = pool[$urandom_range(pool_size - 1)];
      else page = PAGE_BITS'($urandom);
      send_request(page);
      if ($urandom_range(99) < 2) drain_results();
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (directed_pages[i]) send_request(directed_pages[i]);

    run_phase(8'd1, 0, 0, 105);
    run_phase(8'd0, 60, 0, 105);
    run_phase(8'd255, 0, 60, 105);
    // Lowering the interval below the running count forces a wrap.
    run_phase(8'd2, 6, 6, 105);
    run_phase(apr_pkg::INTERVAL_BITS'($urandom_range(16, 4)), 60, 60, 105);
    run_phase(8'd3, 0, 0, 105);

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("aging_page_replacement verification clean");
    end else begin
      $display("aging_page_replacement verification failed");
    end
    $finish;
  end

endmodule
